// File: design/distinct_value_frequency_counter_assert.svh
// ----------------------------------------------------------------------------
// Distinct value frequency counter assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_VALUE_FREQUENCY_COUNTER_ASSERT_SVH
`define DISTINCT_VALUE_FREQUENCY_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS
`define DVFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("dvfc assertion failed");
`define DVFC_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("dvfc assertion failed");
`else
`define DVFC_ASSERT(lbl, prop)
`define DVFC_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// File: design/dvfc_pkg.sv
// ----------------------------------------------------------------------------
// Distinct value frequency counter package
// Table sizes, command codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dvfc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int VALUE_BITS    = 8;
    localparam int COUNT_BITS    = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [USED_BITS-1:0]  USED_FULL = USED_BITS'(TABLE_ENTRIES);

    typedef struct packed {
        logic cnt_en;
        logic wr_en;
    } t_cell_ctl;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] next_count;
    } t_cell_stat;

endpackage

// File: design/dvfc_cell.sv
// ----------------------------------------------------------------------------
// Distinct value frequency counter cell
// One table entry: stored value, saturating count, match and hit chain.
// ----------------------------------------------------------------------------
module dvfc_cell
    import dvfc_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_in_use,
    input  logic                  i_hit_prev,
    output logic                  o_hit_chain,
    output t_cell_stat            o_stat
);

    logic [VALUE_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  w_hit;

    assign w_hit       = i_in_use && (r_value == i_value);
    assign n_count     = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_BITS'(1);
    assign o_hit_chain = i_hit_prev | w_hit;

    assign o_stat.hit        = w_hit;
    assign o_stat.value      = r_value;
    assign o_stat.count      = r_count;
    assign o_stat.next_count = n_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_value <= i_value;
            r_count <= COUNT_BITS'(1);
        end else if (i_ctl.cnt_en) begin
            r_count <= n_count;
        end
    end

endmodule

// File: design/distinct_value_frequency_counter.sv
// ----------------------------------------------------------------------------
// Distinct value frequency counter
// The accepted beat is captured in the job register; the result is registered
// into the output registers once the output is not stalled. No new beat is taken
// while busy; the cell row compares all entries in parallel and updates at most one.
// Reset: synchronous active low; clears fill count, overflow flag and
// handshake state. Entry contents are not cleared.
// ----------------------------------------------------------------------------
`include "distinct_value_frequency_counter_assert.svh"

module distinct_value_frequency_counter
    import dvfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_item_value,
    input  logic [IDX_BITS-1:0]   i_read_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_BITS-1:0]   o_entry_index,
    output logic [VALUE_BITS-1:0] o_entry_value,
    output logic [COUNT_BITS-1:0] o_entry_count,
    output logic                  o_entry_valid,
    output logic                  o_table_full_error,
    output logic [USED_BITS-1:0]  o_entries_used
);

    logic                  r_busy;
    logic                  r_cmd;
    logic [VALUE_BITS-1:0] r_val;
    logic [IDX_BITS-1:0]   r_idx;
    logic [USED_BITS-1:0]  r_used;
    logic [USED_BITS-1:0]  n_used;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  r_out_vld;

    logic [IDX_BITS-1:0]   n_idx;
    logic [VALUE_BITS-1:0] n_value;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_valid;

    logic                  w_done;
    logic                  w_do_count;
    logic                  w_full;
    logic                  w_hit_any;
    logic [IDX_BITS-1:0]   w_hit_idx;
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_wr;
    logic [TABLE_ENTRIES:0]   w_chain;
    t_cell_ctl             w_ctl  [TABLE_ENTRIES];
    t_cell_stat            w_stat [TABLE_ENTRIES];

    assign o_stall    = r_busy;
    assign w_done     = r_busy && (!r_out_vld || !i_stall);
    assign w_do_count = w_done && (r_cmd == CMD_COUNT);
    assign w_full     = (r_used == USED_FULL);
    assign w_chain[0] = 1'b0;
    assign w_hit_any  = w_chain[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_hit[g]         = w_stat[g].hit;
        assign w_wr[g]          = w_do_count && !w_hit_any && !w_full &&
                                  (r_used == USED_BITS'(g));
        assign w_ctl[g].cnt_en  = w_do_count && w_stat[g].hit;
        assign w_ctl[g].wr_en   = w_wr[g];

        dvfc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_value     (r_val),
            .i_in_use    (USED_BITS'(g) < r_used),
            .i_hit_prev  (w_chain[g]),
            .o_hit_chain (w_chain[g+1]),
            .o_stat      (w_stat[g])
        );
    end

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_hit[i]) begin
                w_hit_idx = w_hit_idx | IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        n_used  = r_used;
        n_ovf   = r_ovf;
        n_idx   = '0;
        n_value = '0;
        n_count = '0;
        n_valid = 1'b0;
        case (r_cmd)
            CMD_READ: begin
                n_idx = r_idx;
                if (USED_BITS'(r_idx) < r_used) begin
                    n_value = w_stat[r_idx].value;
                    n_count = w_stat[r_idx].count;
                    n_valid = 1'b1;
                end
            end
            CMD_COUNT: begin
                if (w_hit_any) begin
                    n_idx   = w_hit_idx;
                    n_value = r_val;
                    n_count = w_stat[w_hit_idx].next_count;
                    n_valid = 1'b1;
                end else if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_idx   = r_used[IDX_BITS-1:0];
                    n_value = r_val;
                    n_count = COUNT_BITS'(1);
                    n_valid = 1'b1;
                    n_used  = r_used + USED_BITS'(1);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_used    <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_valid && !r_busy) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_used    <= n_used;
                r_ovf     <= n_ovf;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_busy) begin
            r_cmd <= i_cmd;
            r_val <= i_item_value;
            r_idx <= i_read_index;
        end
        if (w_done) begin
            o_entry_index      <= n_idx;
            o_entry_value      <= n_value;
            o_entry_count      <= n_count;
            o_entry_valid      <= n_valid;
            o_table_full_error <= n_ovf;
            o_entries_used     <= n_used;
        end
    end

    assign o_valid = r_out_vld;

    `DVFC_ASSERT(a_hit_onehot0, $onehot0(w_hit))
    `DVFC_ASSERT(a_wr_exclusive, $onehot0(w_wr) && !(w_hit_any && (w_wr != '0)))
    `DVFC_ASSERT(a_used_bound, r_used <= USED_FULL)
    `DVFC_ASSERT_NEXT(a_ovf_sticky, r_ovf, r_ovf)

endmodule
